>>> design/msli_pkg.sv
// Shared types and codes for the multiway sorted list intersection block.
`default_nettype none
package msli_pkg;

  localparam int unsigned REQ_BITS = 2;
  localparam int unsigned CNT_BITS = 4;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_NEXT  = 2'd2,
    REQ_SKIP  = 2'd3
  } req_t;

endpackage
`default_nettype wire

>>> design/msli_store.sv
// Synchronous id store: one write port, one registered read port.
`default_nettype none
module msli_store #(
  parameter int unsigned MAX_LISTS   = 8,
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned ID_BITS     = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [$clog2(MAX_LISTS*MAX_ENTRIES)-1:0] waddr,
  input  wire logic [ID_BITS-1:0]                      wdata,
  input  wire logic                                    re,
  input  wire logic [$clog2(MAX_LISTS*MAX_ENTRIES)-1:0] raddr,
  output logic      [ID_BITS-1:0]                      rdata
);

  localparam int unsigned DEPTH = MAX_LISTS * MAX_ENTRIES;

  logic [ID_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> design/multiway_sorted_list_intersection_top.sv
// Top level: list loading, head tracking and the intersection sequencer.
//
// Usage: set lists_in_use through cfg_we/cfg_wdata while idle. Send load beats
// (req_type 0) to fill each list in ascending order; entry_is_last sets the
// list length. A start beat (req_type 1) puts the head of each non-empty list
// in use on its largest entry, reading the id store once per list in use.
// A next beat (req_type 2) returns one result beat: hit_id with hit_found 1,
// or hit_id 0 with hit_found 0 when any list in use runs out. A skip beat
// (req_type 3) discards skip_count hits and returns nothing.
// Each head move of a next beat is a binary search over the id store, one
// registered read per step, and each round scans the lists in use one by
// one; the time taken is data dependent.
// One beat is worked on at a time; in_ready is low while busy. A result waits
// in the output register while out_ready is low; the next beat may be taken
// meanwhile, and a next beat finishing stalls until the register is free.
// Reset (rst, synchronous) clears list lengths, heads and lists_in_use to 1;
// id store contents stay undefined until written.
`default_nettype none
module multiway_sorted_list_intersection_top #(
  parameter int unsigned MAX_LISTS   = 8,
  parameter int unsigned MAX_ENTRIES = 1024,
  parameter int unsigned ID_BITS     = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  req_type,
  input  wire logic [2:0]  list_select,
  input  wire logic [9:0]  entry_pos,
  input  wire logic [31:0] entry_id,
  input  wire logic        entry_is_last,
  input  wire logic [15:0] skip_count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      hit_id,
  output logic             hit_found
);

  localparam int unsigned LB = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int unsigned PB = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned LENB = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AB = $clog2(MAX_LISTS * MAX_ENTRIES);
  localparam int unsigned NB = $clog2(MAX_LISTS + 1);
  localparam int unsigned CNT_BITS_L = msli_pkg::CNT_BITS;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_STRD   = 10'b0000000010,
    S_STWR   = 10'b0000000100,
    S_SCAN   = 10'b0000001000,
    S_DECIDE = 10'b0000010000,
    S_RD0    = 10'b0000100000,
    S_CHK0   = 10'b0001000000,
    S_BRD    = 10'b0010000000,
    S_BCHK   = 10'b0100000000,
    S_DONE   = 10'b1000000000
  } state_t;

  state_t state;
  logic [CNT_BITS_L-1:0] lists_in_use;

  logic [LENB-1:0]    list_length [MAX_LISTS];
  logic [PB-1:0]      head_pos    [MAX_LISTS];
  logic [ID_BITS-1:0] head_id     [MAX_LISTS];
  logic [MAX_LISTS-1:0] head_valid;

  logic               is_skip;
  logic [15:0]        skip_left;
  logic [LB-1:0]      idx;
  logic [ID_BITS-1:0] small_id, big_id, target;
  logic [LB-1:0]      big_idx;
  logic [LB-1:0]      seek_k;
  logic [PB:0]        lo, hi;
  logic               mem_re;
  logic [AB-1:0]      mem_raddr;
  logic [ID_BITS-1:0] mem_rdata;
  logic               mem_we;
  logic [AB-1:0]      mem_waddr;
  logic [NB-1:0]      n_act;
  logic               found;
  logic [ID_BITS-1:0] found_id;
  logic [PB:0]        mid;
  logic               out_load;

  // clamp lists_in_use to 1..MAX_LISTS
  always_comb begin
    if (lists_in_use == '0) begin
      n_act = NB'(1);
    end else if (32'(lists_in_use) > MAX_LISTS) begin
      n_act = NB'(MAX_LISTS);
    end else begin
      n_act = NB'(lists_in_use);
    end
  end

  assign mid = lo + ((hi - lo) >> 1);

  logic load_ok;
  assign load_ok = (32'(list_select) < MAX_LISTS) && (32'(entry_pos) < MAX_ENTRIES);
  assign mem_we = in_valid && in_ready &&
                  (req_type == msli_pkg::REQ_LOAD) && load_ok;
  assign mem_waddr = AB'(32'(list_select) * MAX_ENTRIES + 32'(entry_pos));

  always_comb begin
    mem_re = 1'b0;
    mem_raddr = '0;
    unique case (state)
      S_STRD: begin
        mem_re = 1'b1;
        mem_raddr = AB'(32'(idx) * MAX_ENTRIES + 32'(list_length[idx]) - 32'd1);
      end
      S_RD0: begin
        mem_re = 1'b1;
        mem_raddr = AB'(32'(seek_k) * MAX_ENTRIES);
      end
      S_BRD: begin
        mem_re = 1'b1;
        mem_raddr = AB'(32'(seek_k) * MAX_ENTRIES + 32'(mid));
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  msli_store #(
    .MAX_LISTS(MAX_LISTS), .MAX_ENTRIES(MAX_ENTRIES), .ID_BITS(ID_BITS)
  ) u_store (
    .clk(clk), .we(mem_we), .waddr(mem_waddr),
    .wdata(ID_BITS'(entry_id)),
    .re(mem_re), .raddr(mem_raddr), .rdata(mem_rdata)
  );

  assign in_ready = (state == S_IDLE);

  // a next beat hands its result to the output register
  assign out_load = (state == S_DONE) && !is_skip && (!out_valid || out_ready);

  logic last_list;
  assign last_list = (32'(idx) + 1 >= 32'(n_act));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      lists_in_use <= CNT_BITS_L'(1);
      head_valid <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < MAX_LISTS; i++) begin
        list_length[i] <= '0;
        head_pos[i] <= '0;
        head_id[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        lists_in_use <= cfg_wdata;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            unique case (msli_pkg::req_t'(req_type))
              msli_pkg::REQ_LOAD: begin
                if (load_ok && entry_is_last) begin
                  list_length[LB'(list_select)] <= LENB'(32'(entry_pos) + 1);
                end
              end
              msli_pkg::REQ_START: begin
                idx <= '0;
                state <= S_STRD;
                head_valid <= '0;
                for (int i = 0; i < MAX_LISTS; i++) begin
                  head_pos[i] <= '0;
                  head_id[i] <= '0;
                end
              end
              default: begin
                is_skip <= (req_type == msli_pkg::REQ_SKIP);
                skip_left <= skip_count;
                idx <= '0;
                if (req_type == msli_pkg::REQ_SKIP && skip_count == '0) begin
                  state <= S_IDLE;
                end else begin
                  state <= S_SCAN;
                end
              end
            endcase
          end
        end
        S_STRD: begin
          // empty lists skip the head write and keep no valid head
          if (list_length[idx] == '0) begin
            if (last_list) state <= S_IDLE;
            else idx <= idx + LB'(1);
          end else begin
            state <= S_STWR;
          end
        end
        S_STWR: begin
          head_pos[idx] <= PB'(list_length[idx] - LENB'(1));
          head_id[idx] <= mem_rdata;
          head_valid[idx] <= 1'b1;
          if (last_list) begin
            state <= S_IDLE;
          end else begin
            idx <= idx + LB'(1);
            state <= S_STRD;
          end
        end
        S_SCAN: begin
          // one list per cycle: min, max, exhaustion
          if (!head_valid[idx]) begin
            found <= 1'b0;
            found_id <= '0;
            state <= S_DONE;
          end else begin
            if (idx == '0) begin
              small_id <= head_id[idx];
              big_id <= head_id[idx];
              big_idx <= '0;
            end else begin
              if (head_id[idx] < small_id) small_id <= head_id[idx];
              if (head_id[idx] > big_id) begin
                big_id <= head_id[idx];
                big_idx <= idx;
              end
            end
            if (last_list) state <= S_DECIDE;
            else idx <= idx + LB'(1);
          end
        end
        S_DECIDE: begin
          if (big_id == small_id) begin
            found <= 1'b1;
            found_id <= big_id;
            if (big_id == '0) begin
              head_valid[0] <= 1'b0;
              state <= S_DONE;
            end else begin
              seek_k <= '0;
              target <= big_id - ID_BITS'(1);
              lo <= '0;
              hi <= (PB+1)'(head_pos[0]);
              if (head_pos[0] == '0) begin
                head_valid[0] <= 1'b0;
                state <= S_DONE;
              end else begin
                state <= S_RD0;
              end
            end
          end else begin
            found <= 1'b0;
            seek_k <= big_idx;
            target <= small_id;
            lo <= '0;
            hi <= (PB+1)'(head_pos[big_idx]);
            if (head_pos[big_idx] == '0) begin
              head_valid[big_idx] <= 1'b0;
              idx <= '0;
              state <= S_SCAN;
            end else begin
              state <= S_RD0;
            end
          end
        end
        S_RD0: begin
          state <= S_CHK0;
        end
        S_CHK0: begin
          if (mem_rdata > target) begin
            head_valid[seek_k] <= 1'b0;
            state <= found ? S_DONE : S_SCAN;
            idx <= '0;
          end else if (hi - lo > (PB+1)'(1)) begin
            state <= S_BRD;
          end else begin
            head_pos[seek_k] <= lo[PB-1:0];
            head_id[seek_k] <= mem_rdata;
            state <= found ? S_DONE : S_SCAN;
            idx <= '0;
          end
        end
        S_BRD: begin
          state <= S_BCHK;
        end
        S_BCHK: begin
          logic [PB:0] nlo, nhi;
          nlo = lo;
          nhi = hi;
          if (mem_rdata <= target) begin
            nlo = mid;
            head_id[seek_k] <= mem_rdata;
          end else begin
            nhi = mid;
          end
          lo <= nlo;
          hi <= nhi;
          if (nhi - nlo > (PB+1)'(1)) begin
            state <= S_BRD;
          end else begin
            head_pos[seek_k] <= nlo[PB-1:0];
            // lo stayed at 0 (hi is 1 then): reload its id via one more read
            if (nlo == '0) begin
              state <= S_RD0;
            end else begin
              state <= found ? S_DONE : S_SCAN;
              idx <= '0;
            end
          end
        end
        S_DONE: begin
          if (is_skip) begin
            if (!found || skip_left == 16'd1) begin
              state <= S_IDLE;
            end else begin
              skip_left <= skip_left - 16'd1;
              idx <= '0;
              state <= S_SCAN;
            end
          end else if (out_load) begin
            hit_found <= found;
            hit_id <= found ? 32'(found_id) : 32'd0;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

>>> design/msli_checker.sv
// Port-level checker for the intersection block, bound to the top level.
`default_nettype none
module msli_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic [1:0]  req_type,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] hit_id,
  input wire logic        hit_found
);

  // a miss always reports id zero
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !hit_found |-> hit_id == 32'd0)
    else $error("miss with nonzero id");

  // a result waiting for the receiver holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_id) && $stable(hit_found))
    else $error("stalled result changed");

  // a load beat leaves the block ready on the next cycle
  a_load_quick: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && req_type == msli_pkg::REQ_LOAD |=> in_ready)
    else $error("load beat did not complete in one cycle");

  // a fresh result only follows a busy period
  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without work");

endmodule

bind multiway_sorted_list_intersection_top msli_checker u_msli_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .req_type(req_type), .out_valid(out_valid), .out_ready(out_ready),
  .hit_id(hit_id), .hit_found(hit_found)
);
`default_nettype wire
